// ===== rtl/ibfd_pkg.sv =====
// Package for the IMU binary frame deframer: framing bytes, payload layout,
// and the structs passed between the front, the command queue and the back.
// Depends on nothing.
`default_nettype none

package ibfd_pkg;

    localparam logic [7:0] START_A = 8'h41;
    localparam logic [7:0] START_C = 8'h43;
    localparam logic [7:0] END_Z   = 8'h5A;

    localparam int FRAME_BYTES   = 34;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
    localparam int PAY_AW        = $clog2(PAYLOAD_BYTES);
    // Two payload banks, so one frame can be unpacked while the next arrives.
    localparam int MEM_AW        = PAY_AW + 1;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int VALUE_W       = 33;

    localparam logic [3:0] FID_TIME     = 4'd0;
    localparam logic [3:0] FID_TEMP     = 4'd10;
    localparam logic [3:0] FID_PRESSURE = 4'd11;
    localparam logic [3:0] FID_LAST     = 4'd13;

    typedef struct packed {
        logic is_err;
        logic kind;
        logic bank;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

    // Index of the final byte of a field: time and pressure are 32-bit words.
    function automatic logic [1:0] f_field_last_byte(input logic [3:0] id);
        logic [1:0] r;
        r = ((id == FID_TIME) || (id == FID_PRESSURE)) ? 2'd3 : 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/imu_binary_frame_deframer.sv =====
// Top level of the IMU binary frame deframer: front, command queue and back.
// Depends on ibfd_pkg, ibfd_front, ibfd_cmd_fifo and ibfd_back.
//
// Usage: bytes from the serial link enter on i_valid/o_ready with i_rx_byte.
// A frame is a start byte 'A' or 'C', 32 payload bytes and a closing 'Z'.
// Each good frame gives 14 results on o_valid/i_ready, field ids 0 to 13,
// the last flagged by o_last_field. A stray byte while hunting, or a bad
// closing byte, gives one result with o_status set.
// Input rate: one byte per cycle. A payload byte waits only while both
// payload banks still hold frames being unpacked; other bytes wait only
// while the command queue is full.
// An error command passes through the queue to the back end, which registers
// its result; after the 'Z' the back end takes that frame's command from the queue.
// Output rate: the back end reads one payload byte per cycle, while the
// receiver takes results, through a single read port; for each frame it takes
// the command, makes the first read, then unpacks the 32 payload bytes.
// A stalled receiver holds the output register; the queue and the second
// bank let input continue until both fill.
// Reset (synchronous, active low) returns to hunting and empties the queue.
`default_nettype none

module imu_binary_frame_deframer
    import ibfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [7:0]                i_rx_byte,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic                      o_status,
    output logic [3:0]                o_field_id,
    output logic signed [VALUE_W-1:0] o_field_value,
    output logic                      o_frame_kind,
    output logic                      o_last_field
);

    t_cmd push_cmd;
    t_cmd pop_cmd;
    t_wr  wr;
    t_rel rel;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    ibfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .i_rel     (rel),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_wr      (wr)
    );

    ibfd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ibfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .i_cmd         (pop_cmd),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_rel         (rel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_field_id    (o_field_id),
        .o_field_value (o_field_value),
        .o_frame_kind  (o_frame_kind),
        .o_last_field  (o_last_field)
    );

    // The front must never overwrite a bank that the back is still reading.
    a_no_write_to_released_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr.en && rel.en && (wr.addr[MEM_AW-1] == rel.bank)))
        else $error("payload write into a bank being unpacked");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command queue overflow");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("command queue underflow");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_last_field && (o_field_id == FID_TIME)
                                   && (o_field_value == '0)))
        else $error("malformed error result");

    a_last_is_final_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_status) |-> (o_last_field == (o_field_id == FID_LAST)))
        else $error("last-field flag out of step with field id");

endmodule

`default_nettype wire

// ===== rtl/ibfd_cmd_fifo.sv =====
// Small command queue between the deframer front and its unpacking back end.
// Depends on ibfd_pkg for the command struct.
`default_nettype none

module ibfd_cmd_fifo
    import ibfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_data,
    input  wire  i_pop,
    output t_cmd o_data,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ibfd_front.sv =====
// Deframer front: takes bytes, tracks framing, writes payload into the
// current bank and queues error or frame-complete commands. Uses ibfd_pkg.
`default_nettype none

module ibfd_front
    import ibfd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_rx_byte,
    input  wire        i_q_full,
    input  t_rel       i_rel,
    output logic       o_push,
    output t_cmd       o_cmd,
    output t_wr        o_wr
);

    logic             r_synced;
    logic [POS_W-1:0] r_pos;
    logic             r_kind;
    logic             r_wbank;
    logic [1:0]       r_busy;

    logic n_synced;
    logic [POS_W-1:0] n_pos;
    logic n_kind;
    logic n_wbank;
    logic [1:0] n_busy;
    logic in_payload;
    logic accept;
    logic is_start;

    assign in_payload = r_synced && (r_pos < POS_W'(PAYLOAD_BYTES));
    // A payload byte needs a free bank; any other byte may need a queue slot.
    assign o_ready    = in_payload ? !r_busy[r_wbank] : !i_q_full;
    assign accept     = i_valid && o_ready;
    assign is_start   = (i_rx_byte == START_A) || (i_rx_byte == START_C);

    always_comb begin
        n_synced = r_synced;
        n_pos    = r_pos;
        n_kind   = r_kind;
        n_wbank  = r_wbank;
        n_busy   = r_busy;
        o_push   = 1'b0;
        o_cmd    = '{is_err: 1'b1, kind: 1'b0, bank: r_wbank};
        o_wr     = '{en: 1'b0, addr: {r_wbank, r_pos[PAY_AW-1:0]}, data: i_rx_byte};
        if (i_rel.en) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (accept) begin
            if (!r_synced) begin
                if (is_start) begin
                    n_synced = 1'b1;
                    n_pos    = '0;
                    n_kind   = (i_rx_byte == START_C);
                end else begin
                    o_push = 1'b1;
                end
            end else if (in_payload) begin
                o_wr.en = 1'b1;
                n_pos   = r_pos + 1'b1;
            end else begin
                n_synced = 1'b0;
                n_pos    = '0;
                o_push   = 1'b1;
                o_cmd.kind = r_kind;
                if (i_rx_byte == END_Z) begin
                    o_cmd.is_err   = 1'b0;
                    n_busy[r_wbank] = 1'b1;
                    n_wbank        = !r_wbank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0;
            r_pos    <= '0;
            r_kind   <= 1'b0;
            r_wbank  <= 1'b0;
            r_busy   <= '0;
        end else begin
            r_synced <= n_synced;
            r_pos    <= n_pos;
            r_kind   <= n_kind;
            r_wbank  <= n_wbank;
            r_busy   <= n_busy;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ibfd_back.sv =====
// Deframer back end: holds the two-bank payload memory, takes commands from
// the queue and, while the receiver takes results, unpacks a frame one byte per cycle into field results.
// Uses ibfd_pkg.
`default_nettype none

module ibfd_back
    import ibfd_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_wr                      i_wr,
    input  t_cmd                     i_cmd,
    input  wire                      i_q_empty,
    output logic                     o_pop,
    output t_rel                     o_rel,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic                     o_status,
    output logic [3:0]               o_field_id,
    output logic signed [VALUE_W-1:0] o_field_value,
    output logic                     o_frame_kind,
    output logic                     o_last_field
);

    logic [7:0]       r_mem [2**MEM_AW];
    logic [7:0]       r_rdata;
    logic             r_rd_valid;
    logic             r_active;
    logic             r_bank;
    logic             r_kind;
    logic [POS_W-1:0] r_rcnt;
    logic [3:0]       r_fid;
    logic [1:0]       r_bif;
    logic [23:0]      r_acc;

    logic out_free;
    logic complete;
    logic consume;
    logic issue;
    logic load_err;
    logic [15:0] w16;
    logic [VALUE_W-1:0] value;

    assign out_free = !o_valid || i_ready;
    assign complete = (r_bif == f_field_last_byte(r_fid));
    assign consume  = r_active && r_rd_valid && (!complete || out_free);
    assign issue    = r_active && (r_rcnt < POS_W'(PAYLOAD_BYTES)) && (!r_rd_valid || consume);
    assign o_pop    = !r_active && !i_q_empty && (!i_cmd.is_err || out_free);
    assign load_err = o_pop && i_cmd.is_err;
    assign o_rel    = '{en: consume && complete && (r_fid == FID_LAST), bank: r_bank};

    assign w16 = {r_rdata, r_acc[7:0]};
    always_comb begin
        if (f_field_last_byte(r_fid) == 2'd3) begin
            value = {1'b0, r_rdata, r_acc};
        end else if (r_fid == FID_TEMP) begin
            value = {17'd0, w16};
        end else begin
            value = {{17{r_rdata[7]}}, w16};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rdata <= r_mem[{r_bank, r_rcnt[PAY_AW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rd_valid <= 1'b0;
            r_rcnt     <= '0;
            r_fid      <= '0;
            r_bif      <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (o_pop && !i_cmd.is_err) begin
                r_active <= 1'b1;
                r_rcnt   <= '0;
                r_fid    <= '0;
                r_bif    <= '0;
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
                r_rcnt     <= r_rcnt + 1'b1;
            end else if (consume) begin
                r_rd_valid <= 1'b0;
            end
            if (consume) begin
                if (complete) begin
                    r_bif <= '0;
                    r_fid <= r_fid + 1'b1;
                    if (r_fid == FID_LAST) begin
                        r_active <= 1'b0;
                    end
                end else begin
                    r_bif <= r_bif + 1'b1;
                end
            end
            if (load_err || (consume && complete)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Result payload and byte accumulator need no reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank <= i_cmd.bank;
            r_kind <= i_cmd.kind;
        end
        if (consume && !complete) begin
            r_acc[8*r_bif +: 8] <= r_rdata;
        end
        if (load_err) begin
            o_status      <= 1'b1;
            o_field_id    <= FID_TIME;
            o_field_value <= '0;
            o_frame_kind  <= i_cmd.kind;
            o_last_field  <= 1'b1;
        end else if (consume && complete) begin
            o_status      <= 1'b0;
            o_field_id    <= r_fid;
            o_field_value <= value;
            o_frame_kind  <= r_kind;
            o_last_field  <= (r_fid == FID_LAST);
        end
    end

endmodule

`default_nettype wire

// ===== dv/imu_binary_frame_deframer_tb.sv =====
// Self-checking testbench for imu_binary_frame_deframer: a short table of framing
// cases, then random frames, broken frames and noise, checked by a model or fixed rows.
// Depends on ibfd_pkg and the RTL of the deframer.
`timescale 1ns / 1ps

module imu_binary_frame_deframer_tb;
    import ibfd_pkg::*;

    localparam logic [3:0] FID_NONE     = 4'd0;
    localparam logic [3:0] FID_ACCEL_X  = 4'd1;
    localparam logic [3:0] FID_OBSTACLE = 4'd12;

    localparam int RANDOM_ITEMS = 44;
    // More stray bytes than the command queue holds, so the input stalls.
    localparam int NOISE_BYTES  = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic               status;
        logic [3:0]         field_id;
        logic [VALUE_W-1:0] value;
        logic               kind;
        logic               last;
    } deframed_field_t;

    typedef struct packed {
        logic [7:0]      rx;
        logic [5:0]      reps;
        logic            fixed;
        deframed_field_t want;
    } stim_row_t;

    localparam deframed_field_t NO_FIELD   = '0;
    localparam deframed_field_t HUNT_ERR   = '{1'b1, FID_NONE, '0, 1'b0, 1'b1};
    localparam deframed_field_t CLOSE_ERR_C = '{1'b1, FID_NONE, '0, 1'b1, 1'b1};

    localparam int NUM_ROWS = 16;
    // Stray bytes while hunting, an all-ones 'A' frame, then a 'C' frame whose
    // payload carries framing bytes and which ends on a bad closing byte.
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h00,   6'd1,  1'b1, HUNT_ERR},
        '{8'hFF,   6'd1,  1'b1, HUNT_ERR},
        '{END_Z,   6'd1,  1'b1, HUNT_ERR},
        '{8'h80,   6'd1,  1'b1, HUNT_ERR},
        '{START_A, 6'd1,  1'b0, NO_FIELD},
        '{8'hFF,   6'd32, 1'b0, NO_FIELD},
        '{END_Z,   6'd1,  1'b0, NO_FIELD},
        '{START_C, 6'd1,  1'b0, NO_FIELD},
        '{START_A, 6'd1,  1'b0, NO_FIELD},
        '{START_C, 6'd1,  1'b0, NO_FIELD},
        '{END_Z,   6'd1,  1'b0, NO_FIELD},
        '{8'h00,   6'd13, 1'b0, NO_FIELD},
        '{8'h7F,   6'd8,  1'b0, NO_FIELD},
        '{8'h80,   6'd8,  1'b0, NO_FIELD},
        '{8'h59,   6'd1,  1'b1, CLOSE_ERR_C},
        '{8'h01,   6'd1,  1'b1, HUNT_ERR}
    };

    logic                      i_clk;
    logic                      i_rst_n   = 1'b0;
    logic                      i_valid   = 1'b0;
    logic [7:0]                i_rx_byte = 8'h00;
    logic                      i_ready   = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic                      o_status;
    logic [3:0]                o_field_id;
    logic signed [VALUE_W-1:0] o_field_value;
    logic                      o_frame_kind;
    logic                      o_last_field;

    imu_binary_frame_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_field_id    (o_field_id),
        .o_field_value (o_field_value),
        .o_frame_kind  (o_frame_kind),
        .o_last_field  (o_last_field)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    deframed_field_t expected_fields [$];
    deframed_field_t fresh_fields [$];
    int unsigned     field_mismatches = 0;
    int unsigned     bytes_taken = 0;
    int unsigned     burst_left = 0;
    int unsigned     cycle_count = 0;
    bit              hold_off_request = 1'b0;

    // Behavioural copy of the deframer state.
    logic       pr_synced = 1'b0;
    logic [5:0] pr_count = '0;
    logic [7:0] pr_payload [PAYLOAD_BYTES];
    logic       pr_kind = 1'b0;

    function automatic deframed_field_t make_field(input logic status, input logic [3:0] id,
                                                   input logic [VALUE_W-1:0] value,
                                                   input logic kind, input logic last);
        deframed_field_t f;
        f.status   = status;
        f.field_id = id;
        f.value    = value;
        f.kind     = kind;
        f.last     = last;
        return f;
    endfunction

    function automatic logic [VALUE_W-1:0] word16(input int unsigned pos, input bit sext);
        logic [15:0] w;
        w = {pr_payload[pos + 1], pr_payload[pos]};
        return sext ? {{17{w[15]}}, w} : {17'b0, w};
    endfunction

    function automatic logic [VALUE_W-1:0] word32(input int unsigned pos);
        return {1'b0, pr_payload[pos + 3], pr_payload[pos + 2], pr_payload[pos + 1],
                pr_payload[pos]};
    endfunction

    // Advances the model by one byte and queues the fields it gives in fresh_fields.
    task automatic deframe_byte(input logic [7:0] rx);
        int i;
        if (!pr_synced) begin
            if (rx == START_A || rx == START_C) begin
                pr_synced = 1'b1;
                pr_count  = '0;
                pr_kind   = (rx == START_C);
            end else begin
                fresh_fields.push_back(make_field(1'b1, FID_NONE, '0, 1'b0, 1'b1));
            end
        end else if (pr_count < PAYLOAD_BYTES) begin
            pr_payload[pr_count] = rx;
            pr_count = pr_count + 1'b1;
        end else begin
            pr_synced = 1'b0;
            pr_count  = '0;
            if (rx != END_Z) begin
                fresh_fields.push_back(make_field(1'b1, FID_NONE, '0, pr_kind, 1'b1));
            end else begin
                fresh_fields.push_back(make_field(1'b0, FID_TIME, word32(0), pr_kind, 1'b0));
                for (i = 0; i < 9; i++)
                    fresh_fields.push_back(make_field(1'b0, FID_ACCEL_X + 4'(i),
                                                      word16(4 + 2 * i, 1'b1), pr_kind, 1'b0));
                fresh_fields.push_back(make_field(1'b0, FID_TEMP, word16(22, 1'b0),
                                                  pr_kind, 1'b0));
                fresh_fields.push_back(make_field(1'b0, FID_PRESSURE, word32(24),
                                                  pr_kind, 1'b0));
                fresh_fields.push_back(make_field(1'b0, FID_OBSTACLE, word16(28, 1'b1),
                                                  pr_kind, 1'b0));
                fresh_fields.push_back(make_field(1'b0, FID_LAST, word16(30, 1'b1),
                                                  pr_kind, 1'b1));
            end
        end
    endtask

    // Entered and left at a falling edge. The sender works in bursts with gaps.
    task automatic send_byte(input logic [7:0] rx, input logic fixed,
                             input deframed_field_t want);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        deframe_byte(rx);
        // A fixed row replaces the model's answer with the one typed into the table.
        if (fixed) begin
            fresh_fields.delete();
            expected_fields.push_back(want);
        end else begin
            while (fresh_fields.size() != 0) expected_fields.push_back(fresh_fields.pop_front());
        end
        bytes_taken++;
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_payload_byte();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0:       b = START_A;
            1:       b = START_C;
            2:       b = END_Z;
            3:       b = 8'h00;
            4:       b = 8'hFF;
            5:       b = 8'h80;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic send_frame(input logic [7:0] close);
        send_byte($urandom_range(0, 1) ? START_C : START_A, 1'b0, NO_FIELD);
        repeat (PAYLOAD_BYTES) send_byte(pick_payload_byte(), 1'b0, NO_FIELD);
        send_byte(close, 1'b0, NO_FIELD);
    endtask

    // Stimulus.
    initial begin
        int unsigned random_goal;
        int unsigned seq;
        int unsigned pick;
        int          r;
        logic [7:0]  b;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < NUM_ROWS; r++)
            repeat (DIRECTED_ROWS[r].reps)
                send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);

        random_goal = bytes_taken + RANDOM_ITEMS;
        seq = 0;
        while (bytes_taken < random_goal) begin
            pick = $urandom_range(0, 99);
            if (seq == 0) begin
                // The sender waits for every expected result. The receiver then holds
                // off while a good frame and a run of stray bytes arrive, so the bank
                // stays busy, the queue fills up and the input stalls.
                i_valid <= 1'b0;
                do @(negedge i_clk); while (expected_fields.size() != 0);
                burst_left = 0;
                hold_off_request = 1'b1;
                send_frame(END_Z);
            end else if (seq == 1) begin
                repeat (NOISE_BYTES) begin
                    do b = 8'($urandom_range(0, 255)); while (b == START_A || b == START_C);
                    send_byte(b, 1'b0, NO_FIELD);
                end
            end else if (pick < 65) begin
                send_frame(END_Z);
            end else if (pick < 78) begin
                do b = 8'($urandom_range(0, 255)); while (b == END_Z);
                send_frame(b);
            end else if (pick < 88) begin
                // Cut-short frame: the next start byte is swallowed as payload.
                send_byte($urandom_range(0, 1) ? START_C : START_A, 1'b0, NO_FIELD);
                repeat ($urandom_range(0, 31)) send_byte(pick_payload_byte(), 1'b0, NO_FIELD);
            end else begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, NO_FIELD);
            end
            seq++;
        end

        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_fields.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (field_mismatches == 0 && expected_fields.size() == 0)
            $display("imu_binary_frame_deframer test passed");
        else
            $display("imu_binary_frame_deframer test failed");
        $finish;
    end

    // Receiver: switches among randomly chosen stall patterns, apart from one long hold-off.
    initial begin
        int unsigned rcv_cycle;
        int unsigned mode;
        rcv_cycle = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_request = 1'b0;
            end
            if (rcv_cycle % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                2:       i_ready <= (rcv_cycle % 4 == 0);
                default: i_ready <= ($urandom_range(0, 4) != 0);
            endcase
            rcv_cycle++;
        end
    end

    // Each taken result against the oldest expected field.
    always @(posedge i_clk) begin
        deframed_field_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_fields.size() == 0) begin
                $error("unexpected result: field_id %0d, status %0d", o_field_id, o_status);
                field_mismatches++;
            end else begin
                want = expected_fields.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    field_mismatches++;
                end
                if (o_field_id !== want.field_id) begin
                    $error("field_id: expected %0d, got %0d", want.field_id, o_field_id);
                    field_mismatches++;
                end
                if (o_field_value !== want.value) begin
                    $error("field_value: expected 0x%09h, got 0x%09h", want.value, o_field_value);
                    field_mismatches++;
                end
                if (o_frame_kind !== want.kind) begin
                    $error("frame_kind: expected %0d, got %0d", want.kind, o_frame_kind);
                    field_mismatches++;
                end
                if (o_last_field !== want.last) begin
                    $error("last_field: expected %0d, got %0d", want.last, o_last_field);
                    field_mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("imu_binary_frame_deframer test failed");
            $finish;
        end
    end

endmodule
